>>> hdl/lrfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrfp_pkg
// Shared constants for the lidar range frame parser: frame markers, validity
// limits, register map and the packing widths of the stream beats.
// ----------------------------------------------------------------------------
package lrfp_pkg;

    localparam logic [7:0]  HEADER_BYTE    = 8'h59;
    localparam logic [3:0]  POS_HUNT       = 4'd0;
    localparam logic [3:0]  POS_SECOND_HDR = 4'd1;
    localparam logic [3:0]  POS_CHECKSUM   = 4'd8;
    localparam logic [15:0] STRENGTH_BAD   = 16'hFFFF;
    localparam logic [15:0] DISTANCE_FAR   = 16'd65532;

    localparam logic        REPORT_INVALID_RESET = 1'b1;
    localparam logic [15:0] MIN_STRENGTH_RESET   = 16'd100;

    localparam int          IN_TDATA_W  = 16;
    localparam int          OUT_TDATA_W = 56;
    localparam int          APB_ADDR_W  = 3;

    typedef enum logic
    {
        REG_REPORT_INVALID = 1'b0,
        REG_MIN_STRENGTH   = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [3:0]  source_sensor;
        logic [15:0] range_cm;
        logic [15:0] signal_strength;
        logic [15:0] temp_code;
        logic        frame_valid;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/lidar_range_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_frame_parser
// Parses interleaved byte streams of up to SENSOR_COUNT serial range sensors
// into distance, strength and temperature results with a validity flag.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle unless a parsed beat waits
// on a result register that has not been taken. The accepting edge also
// registers the sensor's frame bytes from the frame memory, and the parse and
// checksum then run from those registers into the result register.
// Back-to-back beats of the same sensor are handled by forwarding the
// pending memory write. Only the checksum byte of a frame that passes the
// checksum can produce a result beat, and no result comes out while the
// result register holds a beat that has not been taken.
module lidar_range_frame_parser #(
    parameter int SENSOR_COUNT = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: sensor_index[3:0], data_byte[11:4], zero padding.
    input  wire  [lrfp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,

    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // Fields from bit 0: source_sensor[3:0], range_cm[19:4],
    // signal_strength[35:20], temp_code[51:36], frame_valid[52],
    // zero padding.
    output logic [lrfp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [lrfp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import lrfp_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

    logic              report_invalid_reg;
    logic [15:0]       min_strength_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;

    logic [EXT_W-1:0]  in_sensor_ext;
    logic              in_range;
    logic [IDX_W-1:0]  in_idx;
    logic              in_accept;

    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [3:0]        s1_sensor_reg;
    logic [7:0]        s1_byte_reg;
    logic [63:0]       mem_rd_reg;
    logic              fwd_reg;
    logic [63:0]       fwd_data_reg;

    logic [63:0]       frame_mem [SENSOR_COUNT];
    logic [3:0]        pos_reg [SENSOR_COUNT];

    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_free;

    logic [63:0]       fb;
    logic [3:0]        pos;
    logic [3:0]        pos_next;
    logic              mem_we;
    logic [63:0]       mem_wdata;
    logic [7:0]        sum;
    logic              checksum_ok;
    logic [15:0]       range_w;
    logic [15:0]       str;
    logic [15:0]       temp;
    logic              valid;
    logic              emit;
    logic              s1_advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_REPORT_INVALID: prdata = {31'd0, report_invalid_reg};
            REG_MIN_STRENGTH:   prdata = {16'd0, min_strength_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_invalid_reg <= REPORT_INVALID_RESET;
            min_strength_reg   <= MIN_STRENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_REPORT_INVALID)
            begin
                report_invalid_reg <= pwdata[0];
            end
            else
            begin
                min_strength_reg <= pwdata[15:0];
            end
        end
    end

    assign in_sensor_ext = EXT_W'(s_axis_tdata[3:0]);
    assign in_range      = ({1'b0, in_sensor_ext} < (EXT_W + 1)'(SENSOR_COUNT));
    assign in_idx        = in_sensor_ext[IDX_W-1:0];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign fb  = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign pos = (pos_reg[s1_idx_reg] > POS_CHECKSUM) ? POS_HUNT : pos_reg[s1_idx_reg];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mem_wdata[8*i +: 8] = (pos[2:0] == 3'(i)) ? s1_byte_reg : fb[8*i +: 8];
        end
    end

    always_comb
    begin
        sum = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + fb[8*i +: 8];
        end
    end

    assign checksum_ok = (sum == s1_byte_reg);
    assign range_w     = fb[31:16];
    assign str         = fb[47:32];
    assign temp        = fb[63:48];
    assign valid       = (str >= min_strength_reg) && (str != STRENGTH_BAD)
                         && (range_w != 16'd0) && (range_w != DISTANCE_FAR);

    always_comb
    begin
        pos_next = POS_HUNT;
        mem_we   = 1'b0;
        emit     = 1'b0;
        priority if (pos == POS_HUNT)
        begin
            if (s1_byte_reg == HEADER_BYTE)
            begin
                pos_next = POS_SECOND_HDR;
                mem_we   = s1_advance;
            end
        end
        else if (pos == POS_SECOND_HDR && s1_byte_reg != HEADER_BYTE)
        begin
            pos_next = POS_HUNT;
        end
        else if (pos < POS_CHECKSUM)
        begin
            pos_next = pos + 4'd1;
            mem_we   = s1_advance;
        end
        else
        begin
            pos_next = POS_HUNT;
            emit     = checksum_ok && (valid || report_invalid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[s1_idx_reg] <= mem_wdata;
        end
        if (in_accept && in_range)
        begin
            mem_rd_reg    <= frame_mem[in_idx];
            fwd_reg       <= mem_we && (s1_idx_reg == in_idx);
            fwd_data_reg  <= mem_wdata;
            s1_idx_reg    <= in_idx;
            s1_sensor_reg <= s_axis_tdata[3:0];
            s1_byte_reg   <= s_axis_tdata[11:4];
        end
        if (s1_advance && emit)
        begin
            out_reg.source_sensor   <= s1_sensor_reg;
            out_reg.range_cm        <= range_w;
            out_reg.signal_strength <= str;
            out_reg.temp_code       <= temp;
            out_reg.frame_valid     <= valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                pos_reg[i] <= POS_HUNT;
            end
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= in_accept && in_range;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_advance && emit;
            end
            if (s1_advance)
            begin
                pos_reg[s1_idx_reg] <= pos_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.frame_valid, out_reg.temp_code,
                            out_reg.signal_strength, out_reg.range_cm,
                            out_reg.source_sensor};

endmodule
`default_nettype wire
